@@ design/h2r_pkg.sv @@
// Shared types, constants and helpers for the HSV to RGB converter.
package h2r_pkg;

    localparam logic [12:0] HUE_CIRCLE = 13'd5760;
    localparam logic [12:0] HUE_SECTOR = 13'd960;
    localparam logic [8:0]  Q_ONE      = 9'd256;
    // floor(2^16 / 15): (4*rem + 1) * F_RECIP >> 16 equals floor(rem * 256 / 960)
    localparam logic [12:0] F_RECIP    = 13'd4369;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic [12:0] hue;
        logic [8:0]  saturation;
        logic [8:0]  brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } rgb_word_t;

    // front end output: sector, clamped inputs, fraction and p level
    typedef struct packed {
        sector_t    sector;
        logic [8:0] sat;
        logic [8:0] val;
        logic [7:0] frac;
        logic [8:0] p_lvl;
    } front_word_t;

    // level stage output: everything the channel select needs
    typedef struct packed {
        sector_t    sector;
        logic [8:0] val;
        logic [8:0] p_lvl;
        logic [8:0] q_lvl;
        logic [8:0] t_lvl;
    } level_word_t;

    function automatic logic [12:0] sector_base(input sector_t sec);
        logic [12:0] base;
        case (sec)
            SEC_RED:     base = 13'd0;
            SEC_YELLOW:  base = 13'd960;
            SEC_GREEN:   base = 13'd1920;
            SEC_CYAN:    base = 13'd2880;
            SEC_BLUE:    base = 13'd3840;
            SEC_MAGENTA: base = 13'd4800;
            default:     base = 13'd4800;
        endcase
        return base;
    endfunction

    function automatic logic [8:0] clamp_q(input logic [8:0] x);
        return (x > Q_ONE) ? Q_ONE : x;
    endfunction

endpackage

@@ design/hsv_to_rgb_converter.sv @@
// Top level of the HSV to RGB converter: five-stage pipeline.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------------
//  s_      | in        | s_valid / s_ready  | hue, saturation, brightness
//  m_      | out       | m_valid / m_ready  | red, green, blue
//
// One word enters per cycle while the output register is not stalled.
// The five register stages: sector split, fraction and p multiply, s*f and
// s*(1-f), v*(1-sf) and v*(1-s(1-f)), channel select into the output register.
// The whole pipe advances when the output register is empty or taken, so a
// stall freezes every stage with its valid bit; nothing is lost or repeated.
// Synchronous reset clears all valid bits; data registers are not reset.
module hsv_to_rgb_converter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  h2r_pkg::hsv_word_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output h2r_pkg::rgb_word_t m_data
);

    logic                 pipe_en;
    logic                 front_valid;
    h2r_pkg::front_word_t front_word;
    logic                 level_valid;
    h2r_pkg::level_word_t level_word;

    // advance when the output slot is free or being drained
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    h2r_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid),
        .in_word   (s_data),
        .out_valid (front_valid),
        .out_word  (front_word)
    );

    h2r_levels u_levels (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (front_valid),
        .in_word   (front_word),
        .out_valid (level_valid),
        .out_word  (level_word)
    );

    h2r_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (level_valid),
        .in_word   (level_word),
        .out_valid (m_valid),
        .out_word  (m_data)
    );

endmodule

@@ design/h2r_front.sv @@
// Stages 1 and 2: hue wrap, sector split, fraction and p level.
module h2r_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  h2r_pkg::hsv_word_t     in_word,
    output logic                   out_valid,
    output h2r_pkg::front_word_t   out_word
);

    typedef struct packed {
        h2r_pkg::sector_t sector;
        logic [9:0]       rem;
        logic [8:0]       sat;
        logic [8:0]       val;
    } split_word_t;

    logic [12:0]          hue_wrap;
    logic [12:0]          hue_off;
    h2r_pkg::sector_t     sector;
    split_word_t          split_next;
    split_word_t          split_reg;
    logic                 split_valid_reg;
    logic [24:0]          f_prod;
    logic [17:0]          p_prod;
    h2r_pkg::front_word_t front_next;
    h2r_pkg::front_word_t front_reg;
    logic                 front_valid_reg;

    always_comb begin
        hue_wrap = (in_word.hue >= h2r_pkg::HUE_CIRCLE) ?
                   in_word.hue - h2r_pkg::HUE_CIRCLE : in_word.hue;
        if (hue_wrap >= 13'd4800) begin
            sector = h2r_pkg::SEC_MAGENTA;
        end else if (hue_wrap >= 13'd3840) begin
            sector = h2r_pkg::SEC_BLUE;
        end else if (hue_wrap >= 13'd2880) begin
            sector = h2r_pkg::SEC_CYAN;
        end else if (hue_wrap >= 13'd1920) begin
            sector = h2r_pkg::SEC_GREEN;
        end else if (hue_wrap >= h2r_pkg::HUE_SECTOR) begin
            sector = h2r_pkg::SEC_YELLOW;
        end else begin
            sector = h2r_pkg::SEC_RED;
        end
        hue_off           = hue_wrap - h2r_pkg::sector_base(sector);
        split_next.sector = sector;
        split_next.rem    = hue_off[9:0];
        split_next.sat    = h2r_pkg::clamp_q(in_word.saturation);
        split_next.val    = h2r_pkg::clamp_q(in_word.brightness);
    end

    always_comb begin
        // 4*rem + 1 times the reciprocal of 15
        f_prod = 25'({split_reg.rem, 2'b01}) * 25'(h2r_pkg::F_RECIP);
        p_prod = 18'(split_reg.val) * 18'(h2r_pkg::Q_ONE - split_reg.sat);
        front_next.sector = split_reg.sector;
        front_next.sat    = split_reg.sat;
        front_next.val    = split_reg.val;
        front_next.frac   = f_prod[23:16];
        front_next.p_lvl  = p_prod[16:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            split_valid_reg <= 1'b0;
            front_valid_reg <= 1'b0;
        end else if (en) begin
            split_valid_reg <= in_valid;
            front_valid_reg <= split_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            split_reg <= split_next;
            front_reg <= front_next;
        end
    end

    assign out_valid = front_valid_reg;
    assign out_word  = front_reg;

endmodule

@@ design/h2r_levels.sv @@
// Stages 3 and 4: saturation-scaled fraction, then q and t levels.
module h2r_levels (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  h2r_pkg::front_word_t   in_word,
    output logic                   out_valid,
    output h2r_pkg::level_word_t   out_word
);

    typedef struct packed {
        h2r_pkg::sector_t sector;
        logic [8:0]       val;
        logic [8:0]       p_lvl;
        logic [8:0]       sf;
        logic [8:0]       sfc;
    } scale_word_t;

    logic [16:0]          sf_prod;
    logic [17:0]          sfc_prod;
    scale_word_t          scale_next;
    scale_word_t          scale_reg;
    logic                 scale_valid_reg;
    logic [17:0]          q_prod;
    logic [17:0]          t_prod;
    h2r_pkg::level_word_t level_next;
    h2r_pkg::level_word_t level_reg;
    logic                 level_valid_reg;

    always_comb begin
        sf_prod  = 17'(in_word.sat) * 17'(in_word.frac);
        sfc_prod = 18'(in_word.sat) * 18'(h2r_pkg::Q_ONE - 9'(in_word.frac));
        scale_next.sector = in_word.sector;
        scale_next.val    = in_word.val;
        scale_next.p_lvl  = in_word.p_lvl;
        scale_next.sf     = sf_prod[16:8];
        scale_next.sfc    = sfc_prod[16:8];
    end

    // zero saturation leaves sf and sfc at zero, so q and t come out as v
    always_comb begin
        q_prod = 18'(scale_reg.val) * 18'(h2r_pkg::Q_ONE - scale_reg.sf);
        t_prod = 18'(scale_reg.val) * 18'(h2r_pkg::Q_ONE - scale_reg.sfc);
        level_next.sector = scale_reg.sector;
        level_next.val    = scale_reg.val;
        level_next.p_lvl  = scale_reg.p_lvl;
        level_next.q_lvl  = q_prod[16:8];
        level_next.t_lvl  = t_prod[16:8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_valid_reg <= 1'b0;
            level_valid_reg <= 1'b0;
        end else if (en) begin
            scale_valid_reg <= in_valid;
            level_valid_reg <= scale_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            scale_reg <= scale_next;
            level_reg <= level_next;
        end
    end

    assign out_valid = level_valid_reg;
    assign out_word  = level_reg;

endmodule

@@ design/h2r_select.sv @@
// Stage 5: route v, p, q and t to the channels by sector; output register.
module h2r_select (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  h2r_pkg::level_word_t   in_word,
    output logic                   out_valid,
    output h2r_pkg::rgb_word_t     out_word
);

    h2r_pkg::rgb_word_t rgb_next;
    h2r_pkg::rgb_word_t rgb_reg;
    logic               rgb_valid_reg;

    always_comb begin
        case (in_word.sector)
            h2r_pkg::SEC_RED: begin
                rgb_next = '{red: in_word.val, green: in_word.t_lvl, blue: in_word.p_lvl};
            end
            h2r_pkg::SEC_YELLOW: begin
                rgb_next = '{red: in_word.q_lvl, green: in_word.val, blue: in_word.p_lvl};
            end
            h2r_pkg::SEC_GREEN: begin
                rgb_next = '{red: in_word.p_lvl, green: in_word.val, blue: in_word.t_lvl};
            end
            h2r_pkg::SEC_CYAN: begin
                rgb_next = '{red: in_word.p_lvl, green: in_word.q_lvl, blue: in_word.val};
            end
            h2r_pkg::SEC_BLUE: begin
                rgb_next = '{red: in_word.t_lvl, green: in_word.p_lvl, blue: in_word.val};
            end
            default: begin
                rgb_next = '{red: in_word.val, green: in_word.p_lvl, blue: in_word.q_lvl};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rgb_valid_reg <= 1'b0;
        end else if (en) begin
            rgb_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = rgb_valid_reg;
    assign out_word  = rgb_reg;

endmodule

@@ design/h2r_checker.sv @@
// Port-level checker for the HSV to RGB converter, bound to the top level.
module h2r_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input h2r_pkg::hsv_word_t s_data,
    input logic               m_valid,
    input logic               m_ready,
    input h2r_pkg::rgb_word_t m_data
);

    // a waiting input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // every channel stays within 0..1.0
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.red <= 9'd256) && (m_data.green <= 9'd256)
                    && (m_data.blue <= 9'd256))
        else $error("result channel above full scale");

    // input is taken whenever the output slot is free or draining
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output slot");

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (.*);
